@@ rtl/core/text_console_writer_core_defines.svh @@
// Assertion macros used by the checker file of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// Shared constants, command codes and helpers of the text console writer.
package tcw_pkg;

	// Default screen geometry and queue depth.
	localparam int unsigned DEF_COLUMNS = 80;
	localparam int unsigned DEF_ROWS    = 25;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Character and attribute constants.
	localparam logic [7:0] NEWLINE_CODE    = 8'd10;
	localparam logic [7:0] BLANK_CODE      = 8'd32;
	localparam logic [7:0] RESET_ATTRIBUTE = 8'h02;

	// Item kinds as they arrive on the input port.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Commands passed from the front end to the back end.
	localparam int unsigned OP_W = 3;
	typedef enum logic [OP_W-1:0] {
		OP_NONE    = 3'd0,
		OP_CHAR    = 3'd1,
		OP_NEWLINE = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	// A cell holds the attribute in the high byte and the character in the low byte.
	function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
		return {attr, ch};
	endfunction

endpackage

@@ rtl/core/text_console_writer_core.sv @@
// Top level of the character-cell text console writer.
// The console keeps a ROWS x COLUMNS store of cells (character in the low byte,
// attribute in the high byte) and a cursor. A word of kind 0 writes a character
// (10 is newline), kind 1 clears the screen and homes the cursor, kind 2 reads one
// cell; every word gives exactly one result word carrying the linear cursor
// position, and for a read the cell's character and attribute. After reset the
// store is swept to spaces with attribute 2 with full held high; cfg_we may be
// used during that time. The back end carries out one command at a time and takes
// the next only when it is done: a character, newline or unused kind is handled
// from idle, a read passes through a read state, a clear sweeps the whole store,
// and a character or newline that finds the cursor below the last row first scrolls.
// A result word is offered only after its word has passed the command queue and the back end.
module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int unsigned ROWS    = DEF_ROWS,
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	localparam int unsigned CELL_COUNT = ROWS * COLUMNS,
	localparam int unsigned IDX_W      = $clog2(CELL_COUNT),
	localparam int unsigned POS_W      = $clog2(CELL_COUNT + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [1:0]       kind,
	input  logic [7:0]       char_code,
	input  logic [IDX_W-1:0] cell_index,
	output logic             empty,
	input  logic             pop,
	output logic [POS_W-1:0] cursor_position,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attribute,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata
);

	localparam int unsigned CMD_W = OP_W + 8 + IDX_W;
	localparam int unsigned RES_W = POS_W + 16;

	logic             init_busy;
	logic             cmd_full;
	logic             cmd_push;
	op_t              front_op;
	logic [7:0]       front_char;
	logic [IDX_W-1:0] front_index;
	logic [CMD_W-1:0] cmd_rdata;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	logic [POS_W-1:0] res_position;
	logic [7:0]       res_char;
	logic [7:0]       res_attr;
	logic [RES_W-1:0] res_rdata;

	// Classification of incoming words.
	tcw_front #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_front (
		.push       (push),
		.full       (full),
		.kind       (kind),
		.char_code  (char_code),
		.cell_index (cell_index),
		.init_busy  (init_busy),
		.q_full     (cmd_full),
		.q_push     (cmd_push),
		.q_op       (front_op),
		.q_char     (front_char),
		.q_index    (front_index)
	);

	// Command queue between the front and back ends.
	tcw_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  ({front_op, front_char, front_index}),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	// Execution against the screen store.
	tcw_back #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd_empty    (cmd_empty),
		.cmd_op       (op_t'(cmd_rdata[CMD_W-1 -: OP_W])),
		.cmd_char     (cmd_rdata[IDX_W +: 8]),
		.cmd_index    (cmd_rdata[IDX_W-1:0]),
		.cmd_pop      (cmd_pop),
		.res_full     (res_full),
		.res_push     (res_push),
		.res_position (res_position),
		.res_char     (res_char),
		.res_attr     (res_attr),
		.init_busy    (init_busy)
	);

	// Result queue towards the consumer.
	tcw_queue #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_position, res_char, res_attr}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign cursor_position = res_rdata[RES_W-1 -: POS_W];
	assign cell_char       = res_rdata[15:8];
	assign cell_attribute  = res_rdata[7:0];

endmodule

@@ rtl/core/tcw_queue.sv @@
// Small register-based first-in first-out queue of words.
module tcw_queue
	import tcw_pkg::*;
#(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/core/tcw_front.sv @@
// Front end: accepts input words and turns them into back-end commands.
module tcw_front
	import tcw_pkg::*;
#(
	parameter int unsigned ROWS    = DEF_ROWS,
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	localparam int unsigned CELL_COUNT = ROWS * COLUMNS,
	localparam int unsigned IDX_W      = $clog2(CELL_COUNT)
) (
	input  logic             push,
	output logic             full,
	input  logic [1:0]       kind,
	input  logic [7:0]       char_code,
	input  logic [IDX_W-1:0] cell_index,
	input  logic             init_busy,
	input  logic             q_full,
	output logic             q_push,
	output op_t              q_op,
	output logic [7:0]       q_char,
	output logic [IDX_W-1:0] q_index
);

	logic index_ok;

	// Nothing is taken while the store is being cleared after reset.
	assign full    = q_full || init_busy;
	assign q_push  = push && !full;
	assign q_char  = char_code;
	assign q_index = cell_index;

	assign index_ok = ({1'b0, cell_index} < (IDX_W + 1)'(CELL_COUNT));

	// Classify the word. A read outside the store behaves like an unused kind.
	always_comb begin
		unique case (kind)
			KIND_WRITE: q_op = (char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_CHAR;
			KIND_CLEAR: q_op = OP_CLEAR;
			KIND_READ:  q_op = index_ok ? OP_READ : OP_NONE;
			default:    q_op = OP_NONE;
		endcase
	end

endmodule

@@ rtl/core/tcw_back.sv @@
// Back end: owns the screen store and the cursor and carries out commands.
module tcw_back
	import tcw_pkg::*;
#(
	parameter int unsigned ROWS    = DEF_ROWS,
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	localparam int unsigned CELL_COUNT = ROWS * COLUMNS,
	localparam int unsigned ADDR_W     = $clog2(CELL_COUNT),
	localparam int unsigned POS_W      = $clog2(CELL_COUNT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              cmd_empty,
	input  op_t               cmd_op,
	input  logic [7:0]        cmd_char,
	input  logic [ADDR_W-1:0] cmd_index,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output logic [POS_W-1:0]  res_position,
	output logic [7:0]        res_char,
	output logic [7:0]        res_attr,
	output logic              init_busy
);

	localparam int unsigned ROW_W    = $clog2(ROWS + 1);
	localparam int unsigned COL_W    = $clog2(COLUMNS);
	localparam int unsigned LAST_ROW = (ROWS - 1) * COLUMNS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_READ  = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic              init_q, init_d;
	logic              scroll_q, scroll_d;
	logic [ADDR_W-1:0] sweep_q, sweep_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [POS_W-1:0]  base_q, base_d;
	logic [7:0]        attr_q;

	logic              wr_valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              wr_blank_s1;

	logic [15:0]       mem [CELL_COUNT];
	logic [15:0]       rd_data_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	logic              go;
	logic              bottom;
	logic              sweep_last;
	logic              in_last_row;
	logic [ADDR_W-1:0] src_addr;
	logic [15:0]       blank_cell;

	assign init_busy   = init_q;
	assign go          = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign bottom      = (row_q == ROW_W'(ROWS));
	assign sweep_last  = (sweep_q == ADDR_W'(CELL_COUNT - 1));
	assign in_last_row = (sweep_q >= ADDR_W'(LAST_ROW));
	assign src_addr    = in_last_row ? '0 : sweep_q + ADDR_W'(COLUMNS);
	assign blank_cell  = make_cell(BLANK_CODE, init_q ? RESET_ATTRIBUTE : attr_q);

	// Store ports: a pending sweep write wins; otherwise a character write from idle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = wr_blank_s1 ? blank_cell : rd_data_q;
		if (wr_valid_s1) begin
			mem_we = 1'b1;
		end else if (go && (cmd_op == OP_CHAR) && !bottom) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q[ADDR_W-1:0];
			mem_wdata = make_cell(cmd_char, attr_q);
		end
		mem_raddr = (state_q == ST_IDLE) ? cmd_index : src_addr;
	end

	// Command sequencing and cursor update.
	always_comb begin
		state_d      = state_q;
		init_d       = init_q;
		scroll_d     = scroll_q;
		sweep_d      = sweep_q;
		row_d        = row_q;
		col_d        = col_q;
		pos_d        = pos_q;
		base_d       = base_q;
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res_position = pos_q;
		res_char     = '0;
		res_attr     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					unique case (cmd_op)
						OP_CHAR: begin
							if (bottom) begin
								scroll_d = 1'b1;
								sweep_d  = '0;
								state_d  = ST_SWEEP;
							end else begin
								pos_d = pos_q + POS_W'(1);
								if (col_q == COL_W'(COLUMNS - 1)) begin
									col_d  = '0;
									row_d  = row_q + ROW_W'(1);
									base_d = base_q + POS_W'(COLUMNS);
								end else begin
									col_d = col_q + COL_W'(1);
								end
								res_position = pos_q + POS_W'(1);
								res_push     = 1'b1;
								cmd_pop      = 1'b1;
							end
						end
						OP_NEWLINE: begin
							if (bottom) begin
								scroll_d = 1'b1;
								sweep_d  = '0;
								state_d  = ST_SWEEP;
							end else begin
								row_d        = row_q + ROW_W'(1);
								col_d        = '0;
								base_d       = base_q + POS_W'(COLUMNS);
								pos_d        = base_q + POS_W'(COLUMNS);
								res_position = base_q + POS_W'(COLUMNS);
								res_push     = 1'b1;
								cmd_pop      = 1'b1;
							end
						end
						OP_CLEAR: begin
							scroll_d = 1'b0;
							sweep_d  = '0;
							state_d  = ST_SWEEP;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
							res_push = 1'b1;
							cmd_pop  = 1'b1;
						end
					endcase
				end
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d = ST_DRAIN;
				end else begin
					sweep_d = sweep_q + ADDR_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
				if (init_q) begin
					init_d = 1'b0;
				end else if (scroll_q) begin
					// The waiting command is handled again from the last row.
					row_d  = ROW_W'(ROWS - 1);
					col_d  = '0;
					pos_d  = POS_W'(LAST_ROW);
					base_d = POS_W'(LAST_ROW);
				end else begin
					row_d        = '0;
					col_d        = '0;
					pos_d        = '0;
					base_d       = '0;
					res_position = '0;
					res_push     = 1'b1;
					cmd_pop      = 1'b1;
				end
			end
			ST_READ: begin
				res_char = rd_data_q[7:0];
				res_attr = rd_data_q[15:8];
				res_push = 1'b1;
				cmd_pop  = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers; reset starts the clearing pass over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_q      <= 1'b1;
			scroll_q    <= 1'b0;
			sweep_q     <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			base_q      <= '0;
			attr_q      <= RESET_ATTRIBUTE;
			wr_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			init_q      <= init_d;
			scroll_q    <= scroll_d;
			sweep_q     <= sweep_d;
			row_q       <= row_d;
			col_q       <= col_d;
			pos_q       <= pos_d;
			base_q      <= base_d;
			wr_valid_s1 <= (state_q == ST_SWEEP);
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
		end
	end

	// Sweep write stage: the copy source is read in the cycle before its write.
	always_ff @(posedge clk) begin
		wr_addr_s1  <= sweep_q;
		wr_blank_s1 <= !scroll_q || in_last_row;
	end

	// Screen store with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[mem_raddr];
	end

endmodule

@@ rtl/core/tcw_checker.sv @@
// Port-level checks of the text console writer and their binding to the top level.
`include "text_console_writer_core_defines.svh"

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int unsigned ROWS    = DEF_ROWS,
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	localparam int unsigned CELL_COUNT = ROWS * COLUMNS,
	localparam int unsigned POS_W      = $clog2(CELL_COUNT + 1)
) (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input logic [POS_W-1:0] cursor_position,
	input logic [7:0]       cell_char,
	input logic [7:0]       cell_attribute
);

	// A waiting word is not withdrawn before it is taken.
	`TCW_ASSERT_NXT(a_result_held, clk, arst_n, !empty && !pop, !empty, "result word withdrawn")

	// A waiting word does not change before it is taken.
	`TCW_ASSERT_NXT(a_result_stable, clk, arst_n, !empty && !pop,
		$stable(cursor_position) && $stable(cell_char) && $stable(cell_attribute),
		"result word changed while waiting")

	// The cursor never lies beyond one past the last cell.
	`TCW_ASSERT_IMP(a_cursor_range, clk, arst_n, !empty,
		cursor_position <= POS_W'(CELL_COUNT), "cursor position out of range")

	// Leaving reset, the clearing pass keeps input closed and no result waits.
	`TCW_ASSERT_IMP(a_reset_sweep, clk, arst_n, $rose(arst_n), full && empty,
		"words open during clearing pass")

endmodule

bind text_console_writer_core tcw_checker #(
	.ROWS    (ROWS),
	.COLUMNS (COLUMNS)
) u_tcw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.full            (full),
	.empty           (empty),
	.pop             (pop),
	.cursor_position (cursor_position),
	.cell_char       (cell_char),
	.cell_attribute  (cell_attribute)
);
